[src/crc_checked_frame_deframer_defines.svh]
// assertion helpers for the deframer module
`ifndef CRC_CHECKED_FRAME_DEFRAMER_DEFINES_SVH
`define CRC_CHECKED_FRAME_DEFRAMER_DEFINES_SVH

// same-cycle implication, checked outside reset
`define CCFD_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, checked outside reset
`define CCFD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

[src/ccfd_pkg.sv]
package ccfd_pkg;

  localparam int STREAM_BYTES_LOG2 = 26;
  localparam int POS_W             = STREAM_BYTES_LOG2 + 1;

  localparam int MAX_LEN_W = 25;
  localparam logic [MAX_LEN_W-1:0] MAX_LEN_RESET = MAX_LEN_W'(16 * 1024 * 1024);

  localparam logic [31:0] CRC_POLY = 32'hEDB8_8320;
  localparam logic [31:0] CRC_INIT = 32'hFFFF_FFFF;

  localparam int IDX_W = 24;
  localparam int OFF_W = 27;
  localparam int LEN_W = 32;
  localparam int ST_W  = 3;

  localparam logic [ST_W-1:0] ST_OK        = 3'd0;
  localparam logic [ST_W-1:0] ST_CRC_BAD   = 3'd1;
  localparam logic [ST_W-1:0] ST_ZERO_LEN  = 3'd2;
  localparam logic [ST_W-1:0] ST_TOO_LONG  = 3'd3;
  localparam logic [ST_W-1:0] ST_TRUNCATED = 3'd4;
  localparam logic [ST_W-1:0] ST_DONE      = 3'd5;

  // result queue
  localparam int RES_DEPTH = 4;
  localparam int RES_PTR_W = 2;
  localparam int RES_CNT_W = 3;

  typedef enum logic [1:0] {
    PH_HEADER,
    PH_PAYLOAD,
    PH_HALTED
  } phase_t;

  typedef struct packed {
    logic [ST_W-1:0]  status;
    logic [IDX_W-1:0] frame_index;
    logic [OFF_W-1:0] frame_offset;
    logic [LEN_W-1:0] payload_length;
    logic             last_result;
  } res_t;

  // up to two results per byte, in order
  typedef struct packed {
    logic [1:0] cnt;
    res_t       first;
    res_t       second;
  } res_push_t;

  function automatic logic [31:0] crc32_byte(input logic [31:0] crc, input logic [7:0] b);
    logic [31:0] c;
    c = crc ^ {24'd0, b};
    for (int i = 0; i < 8; i++) begin
      c = (c >> 1) ^ (CRC_POLY & {32{c[0]}});
    end
    return c;
  endfunction

endpackage

[src/ccfd_res_fifo.sv]
module ccfd_res_fifo
  import ccfd_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  res_push_t            push,
  output res_t                 head,
  output logic                 head_valid,
  input  logic                 head_pop,
  output logic [RES_CNT_W-1:0] count
);

  res_t                 entry_r [RES_DEPTH];
  logic [RES_PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [RES_PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [RES_CNT_W-1:0] count_r, count_nxt;
  logic [RES_PTR_W-1:0] wr_ptr_plus1;
  logic                 pop;

  assign head_valid   = (count_r != '0);
  assign head         = entry_r[rd_ptr_r];
  assign count        = count_r;
  assign pop          = head_valid && head_pop;
  assign wr_ptr_plus1 = wr_ptr_r + RES_PTR_W'(1);

  always_comb begin
    wr_ptr_nxt = wr_ptr_r + RES_PTR_W'(push.cnt);
    rd_ptr_nxt = rd_ptr_r + RES_PTR_W'(pop);
    count_nxt  = count_r + RES_CNT_W'(push.cnt) - RES_CNT_W'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < RES_DEPTH; i++) begin
      if (push.cnt != 2'd0 && RES_PTR_W'(i) == wr_ptr_r) begin
        entry_r[i] <= push.first;
      end else if (push.cnt == 2'd2 && RES_PTR_W'(i) == wr_ptr_plus1) begin
        entry_r[i] <= push.second;
      end
    end
  end

endmodule

[src/crc_checked_frame_deframer.sv]
// Frame deframer with CRC-32 check for a byte stream of length-prefixed frames.
// in_*  : one stream byte per request in in_tdata, in_tlast marks the final byte.
// out_* : one report per request; out_tuser carries the status, out_tlast marks
//         the last report caused by one input byte. A byte causes zero, one
//         or two reports (a final byte that closes a good frame gives ok, then done).
// cfg_* : writes the largest accepted payload length; always ready; the user
//         must write it only while no byte is in flight; the block leaves this to the user.
// Timing: a byte is registered on acceptance, decoded and checked in the next
// cycle (byte-wide CRC update, header compare), and its reports are written
// to the report queue, whose head drives the output, in the cycle after decode.
// Throughput: one byte per cycle while the receiver keeps up; a byte is taken
// as long as the 4-entry report queue, counting the reports of the byte in
// decode, keeps room for two more reports.
// When the receiver stalls, reports collect in the queue and in_tready drops
// once it can no longer hold two more per byte; nothing is lost.
// Reset (synchronous, active low) empties the queue, returns to the header of
// the first frame and restores the length limit to 16 MiB. After an error or
// the end of stream, further bytes are accepted and ignored until reset.
`include "crc_checked_frame_deframer_defines.svh"

module crc_checked_frame_deframer
  import ccfd_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  // in_tdata: [7:0] stream_byte
  input  logic [7:0]           in_tdata,
  input  logic                 in_tlast,
  input  logic                 in_tvalid,
  output logic                 in_tready,
  // out_tdata: [23:0] frame_index, [50:24] frame_offset, [82:51] payload_length,
  //            [87:83] zero
  output logic [87:0]          out_tdata,
  // out_tuser: [2:0] status
  output logic [ST_W-1:0]      out_tuser,
  output logic                 out_tlast,
  output logic                 out_tvalid,
  input  logic                 out_tready,
  // cfg_data: [24:0] max_payload_length
  input  logic [MAX_LEN_W-1:0] cfg_data,
  input  logic                 cfg_valid,
  output logic                 cfg_ready
);

  logic                 in_valid_r;
  logic [7:0]           in_byte_r;
  logic                 in_eos_r;
  logic [MAX_LEN_W-1:0] max_len_r;

  phase_t               phase_r, phase_nxt;
  logic [2:0]           hdr_cnt_r, hdr_cnt_nxt;
  logic [31:0]          length_r, length_nxt;
  logic [31:0]          exp_crc_r, exp_crc_nxt;
  logic [31:0]          crc_r, crc_nxt;
  logic [31:0]          left_r, left_nxt;
  logic [IDX_W-1:0]     frames_r, frames_nxt;
  logic [POS_W-1:0]     pos_r, pos_nxt;
  logic [POS_W-1:0]     start_r, start_nxt;

  logic [31:0]          crc_upd;
  res_t                 res_a, res_b;
  logic [1:0]           res_n;
  res_push_t            push;
  res_t                 head;
  logic                 head_valid;
  logic [RES_CNT_W-1:0] q_count;
  logic                 in_accept;

  // reports of the byte in decode plus two for the next one must fit
  assign in_tready = (q_count + RES_CNT_W'(push.cnt)) <= RES_CNT_W'(RES_DEPTH - 2);
  assign in_accept = in_tvalid && in_tready;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
      max_len_r  <= MAX_LEN_RESET;
    end else begin
      in_valid_r <= in_accept;
      if (cfg_valid) begin
        max_len_r <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      in_byte_r <= in_tdata;
      in_eos_r  <= in_tlast;
    end
  end

  assign crc_upd = crc32_byte(crc_r, in_byte_r);

  always_comb begin
    phase_nxt   = phase_r;
    hdr_cnt_nxt = hdr_cnt_r;
    length_nxt  = length_r;
    exp_crc_nxt = exp_crc_r;
    crc_nxt     = crc_r;
    left_nxt    = left_r;
    frames_nxt  = frames_r;
    pos_nxt     = pos_r;
    start_nxt   = start_r;
    res_a       = '0;
    res_b       = '0;
    res_n       = 2'd0;

    if (in_valid_r && phase_r != PH_HALTED) begin
      if (pos_r[STREAM_BYTES_LOG2]) begin
        // stream longer than the position counter allows
        res_a     = '{ST_TOO_LONG, frames_r, OFF_W'(pos_r), '0, 1'b0};
        res_n     = 2'd1;
        phase_nxt = PH_HALTED;
      end else begin
        if (phase_r == PH_HEADER) begin
          if (hdr_cnt_r == 3'd0) begin
            start_nxt = pos_r;
          end
          // little-endian words fill from the top down
          if (!hdr_cnt_r[2]) begin
            length_nxt = {in_byte_r, length_r[31:8]};
          end else begin
            exp_crc_nxt = {in_byte_r, exp_crc_r[31:8]};
          end
          hdr_cnt_nxt = hdr_cnt_r + 3'd1;
          if (hdr_cnt_r == 3'd7) begin
            if (length_r == '0) begin
              res_a     = '{ST_ZERO_LEN, frames_r, OFF_W'(start_r), '0, 1'b0};
              res_n     = 2'd1;
              phase_nxt = PH_HALTED;
            end else if (length_r > {{(32 - MAX_LEN_W){1'b0}}, max_len_r}) begin
              res_a     = '{ST_TOO_LONG, frames_r, OFF_W'(start_r), length_r, 1'b0};
              res_n     = 2'd1;
              phase_nxt = PH_HALTED;
            end else begin
              phase_nxt = PH_PAYLOAD;
              left_nxt  = length_r;
              crc_nxt   = CRC_INIT;
            end
          end
        end else begin
          crc_nxt  = crc_upd;
          left_nxt = left_r - 32'd1;
          if (left_r == 32'd1) begin
            if (~crc_upd == exp_crc_r) begin
              res_a      = '{ST_OK, frames_r, OFF_W'(start_r), length_r, 1'b0};
              frames_nxt = frames_r + IDX_W'(1);
              phase_nxt  = PH_HEADER;
            end else begin
              res_a     = '{ST_CRC_BAD, frames_r, OFF_W'(start_r), length_r, 1'b0};
              phase_nxt = PH_HALTED;
            end
            res_n = 2'd1;
          end
        end
        pos_nxt = pos_r + POS_W'(1);

        if (in_eos_r && phase_nxt != PH_HALTED) begin
          if (phase_nxt == PH_HEADER && hdr_cnt_nxt == 3'd0) begin
            res_b = '{ST_DONE, frames_nxt, OFF_W'(pos_nxt), '0, 1'b0};
          end else begin
            res_b = '{ST_TRUNCATED, frames_nxt, OFF_W'(start_nxt),
                      (phase_nxt == PH_PAYLOAD) ? length_r : '0, 1'b0};
          end
          phase_nxt = PH_HALTED;
          if (res_n == 2'd0) begin
            res_a = res_b;
            res_n = 2'd1;
          end else begin
            res_n = 2'd2;
          end
        end
      end
    end

    // mark the final report of this byte
    if (res_n == 2'd2) begin
      res_b.last_result = 1'b1;
    end else begin
      res_a.last_result = 1'b1;
    end
    push = '{res_n, res_a, res_b};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= PH_HEADER;
      hdr_cnt_r <= '0;
      length_r  <= '0;
      exp_crc_r <= '0;
      crc_r     <= CRC_INIT;
      left_r    <= '0;
      frames_r  <= '0;
      pos_r     <= '0;
      start_r   <= '0;
    end else begin
      phase_r   <= phase_nxt;
      hdr_cnt_r <= hdr_cnt_nxt;
      length_r  <= length_nxt;
      exp_crc_r <= exp_crc_nxt;
      crc_r     <= crc_nxt;
      left_r    <= left_nxt;
      frames_r  <= frames_nxt;
      pos_r     <= pos_nxt;
      start_r   <= start_nxt;
    end
  end

  ccfd_res_fifo u_res_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .head       (head),
    .head_valid (head_valid),
    .head_pop   (out_tready),
    .count      (q_count)
  );

  assign out_tvalid = head_valid;
  assign out_tuser  = head.status;
  assign out_tlast  = head.last_result;
  assign out_tdata  = {5'd0, head.payload_length, head.frame_offset, head.frame_index};

  `CCFD_ASSERT_NOW(a_queue_bound, 1'b1, q_count <= RES_CNT_W'(RES_DEPTH), "report queue overflow")
  `CCFD_ASSERT_NEXT(a_halt_sticky, phase_r == PH_HALTED, phase_r == PH_HALTED, "left halted state")
  `CCFD_ASSERT_NOW(a_halt_silent, phase_r == PH_HALTED, push.cnt == 2'd0, "report after halt")
  `CCFD_ASSERT_NOW(a_pos_bound, 1'b1, pos_r <= POS_W'(1) << STREAM_BYTES_LOG2, "position overrun")

endmodule
